// ===== sv/dlc_pkg.sv =====
// ----------------------------------------------------------------------------
// dlc_pkg
// Shared types, constants and code tables for the luma/chroma tile encoder.
// ----------------------------------------------------------------------------
package dlc_pkg;

    localparam int TILE_PIXELS = 16;
    localparam int DIV_BITS    = 17;

    localparam logic [6:0]        ALPHA_GATE = 7'd120;
    localparam logic [16:0]       LUMA_SCALE = 17'd65536;
    localparam logic [16:0]       KEY_SCALE  = 17'd24576;
    localparam logic signed [31:0] DITHER_LO = 32'sd64512;
    localparam logic signed [31:0] DITHER_HI = 32'sd66560;

    typedef enum logic [3:0] {
        S_LOAD,
        S_PIXEL,
        S_PREP,
        S_BLEND,
        S_DIVY_GO,
        S_DIVY_WAIT,
        S_DIVZ_GO,
        S_DIVZ_WAIT,
        S_QUANT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [7:0]        y;
        logic signed [9:0] u;
        logic signed [9:0] v;
        logic signed [9:0] al;
        logic signed [9:0] z;
    } pixel_t;

    typedef struct packed {
        logic mul_en;
        logic dither_hi;
    } quant_ctrl_t;

    typedef struct packed {
        logic        done;
        logic [16:0] quotient;
    } div_status_t;

    function automatic logic [2:0] luma_code(input logic [3:0] idx);
        logic [2:0] c;
        case (idx)
            4'd0, 4'd1:   c = 3'd1;
            4'd2, 4'd3:   c = 3'd7;
            4'd4, 4'd5:   c = 3'd6;
            4'd6, 4'd7:   c = 3'd5;
            4'd8, 4'd9:   c = 3'd4;
            4'd10, 4'd11: c = 3'd3;
            4'd12, 4'd13: c = 3'd2;
            default:      c = 3'd0;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] key_code(input logic [3:0] idx);
        logic [1:0] c;
        case (idx)
            4'd6, 4'd7:   c = 2'd2;
            4'd8, 4'd9:   c = 2'd3;
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: c = 2'd0;
            default:      c = 2'd1;
        endcase
        return c;
    endfunction

    // Chroma gain for near-grey, high-alpha pixels, by chroma distance.
    function automatic logic [4:0] boost_gain(input logic [5:0] d);
        logic [4:0] m;
        if (d inside {[6'd0:6'd4]})        m = 5'd16;
        else if (d inside {[6'd5:6'd8]})   m = 5'd8;
        else if (d inside {[6'd9:6'd11]})  m = 5'd5;
        else if (d inside {[6'd12:6'd15]}) m = 5'd4;
        else if (d inside {[6'd16:6'd20]}) m = 5'd3;
        else if (d inside {[6'd21:6'd31]}) m = 5'd2;
        else                               m = 5'd1;
        return m;
    endfunction

    function automatic logic [8:0] boost_alpha(input logic [5:0] d);
        logic [8:0] a;
        if (d == 6'd0)                     a = 9'd256;
        else if (d inside {[6'd1:6'd4]})   a = 9'd252;
        else if (d inside {[6'd5:6'd8]})   a = 9'd248;
        else if (d inside {[6'd9:6'd11]})  a = 9'd244;
        else if (d inside {[6'd12:6'd15]}) a = 9'd240;
        else if (d inside {[6'd16:6'd20]}) a = 9'd235;
        else if (d inside {[6'd21:6'd31]}) a = 9'd224;
        else                               a = 9'd192;
        return a;
    endfunction

endpackage

// ===== sv/dxt5_luma_chroma_block_encoder.sv =====
// ----------------------------------------------------------------------------
// dxt5_luma_chroma_block_encoder
// 4x4 RGBA tile to 16-byte luma/chroma-alpha block encoder.
// ----------------------------------------------------------------------------
// Pixels of a tile enter in raster order; each is captured, then converted
// and folded into the tile statistics before the next one is taken. After
// the 16th pixel the block stops taking pixels through setup, endpoint
// blending, two 17-step scale divisions on the shared bit-serial divider
// and index quantization of each pixel through the single shared
// multiplier. The 16 encoded bytes then leave one beat per cycle as the sink
// accepts them, and the next tile is taken after the last byte beat.
module dxt5_luma_chroma_block_encoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pix_valid,
    output logic       pix_ready,
    input  logic [7:0] red,
    input  logic [7:0] green,
    input  logic [7:0] blue,
    input  logic [7:0] alpha,
    output logic       byte_valid,
    input  logic       byte_ready,
    output logic [7:0] out_byte,
    output logic [3:0] byte_position,
    output logic       last_byte
);

    dlc_pkg::state_t      state_reg;
    dlc_pkg::state_t      state_next;
    dlc_pkg::pixel_t      pix;
    dlc_pkg::quant_ctrl_t qctrl;
    dlc_pkg::div_status_t div_stat;

    logic [7:0] red_reg, green_reg, blue_reg, alpha_reg;

    logic [3:0]        count_reg;
    logic [7:0]        luma_min_reg, luma_max_reg;
    logic signed [9:0] key_min_reg, key_max_reg;
    logic signed [9:0] low_ep_reg [3];
    logic signed [9:0] high_ep_reg [3];
    logic signed [13:0] sum_reg [3];
    logic [7:0]        low_q_reg [3];
    logic [7:0]        high_q_reg [3];
    logic [7:0]        ymid_reg, zmid_reg;
    logic [7:0]        deny_reg, denz_reg;
    logic [16:0]       sy_reg, sz_reg;
    logic [2:0]        step_reg;
    logic [3:0]        qidx_reg;
    logic [1:0]        qphase_reg;
    logic [47:0]       lbits_reg;
    logic [31:0]       kbits_reg;
    logic [3:0]        byte_cnt_reg;

    logic [7:0]        luma_mem [dlc_pkg::TILE_PIXELS];
    logic signed [9:0] key_mem [dlc_pkg::TILE_PIXELS];
    logic [7:0]        luma_rd_reg;
    logic signed [9:0] key_rd_reg;

    logic              div_start;
    logic [16:0]       div_dividend;
    logic [7:0]        div_divisor;
    logic signed [9:0] q_sample;
    logic [7:0]        q_mid;
    logic [16:0]       q_scale;
    logic [3:0]        q_index;

    // tile setup values
    logic [7:0]  kmin_c, kmax_c;
    logic [8:0]  ysum, zsum;
    logic [7:0]  ymid_c, zmid_c;

    // endpoint blend datapath
    logic [1:0]         comp;
    logic               is_high;
    logic signed [9:0]  ep_sel;
    logic signed [13:0] sum_sel;
    logic signed [16:0] ep_x, avg_x, blend, rounded;
    logic [7:0]         ep_out;
    logic [15:0]        word_lo, word_hi;

    dlc_pixel_conv u_conv (
        .red   (red_reg),
        .green (green_reg),
        .blue  (blue_reg),
        .alpha (alpha_reg),
        .pix   (pix)
    );

    dlc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_stat)
    );

    dlc_quant u_quant (
        .clk    (clk),
        .ctrl   (qctrl),
        .sample (q_sample),
        .mid    (q_mid),
        .scale  (q_scale),
        .index  (q_index)
    );

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dlc_pkg::S_LOAD:      if (pix_valid) state_next = dlc_pkg::S_PIXEL;
            dlc_pkg::S_PIXEL:     state_next = (count_reg == 4'd15) ? dlc_pkg::S_PREP
                                                                   : dlc_pkg::S_LOAD;
            dlc_pkg::S_PREP:      state_next = dlc_pkg::S_BLEND;
            dlc_pkg::S_BLEND:     if (step_reg == 3'd5) state_next = dlc_pkg::S_DIVY_GO;
            dlc_pkg::S_DIVY_GO:   state_next = dlc_pkg::S_DIVY_WAIT;
            dlc_pkg::S_DIVY_WAIT: if (div_stat.done) state_next = dlc_pkg::S_DIVZ_GO;
            dlc_pkg::S_DIVZ_GO:   state_next = dlc_pkg::S_DIVZ_WAIT;
            dlc_pkg::S_DIVZ_WAIT: if (div_stat.done) state_next = dlc_pkg::S_QUANT;
            dlc_pkg::S_QUANT:
                if (qphase_reg == 2'd3 && qidx_reg == 4'd15)
                    state_next = dlc_pkg::S_EMIT;
            dlc_pkg::S_EMIT:
                if (byte_ready && byte_cnt_reg == 4'd15)
                    state_next = dlc_pkg::S_LOAD;
            default:              state_next = dlc_pkg::S_LOAD;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb
    begin
        pix_ready        = 1'b0;
        byte_valid       = 1'b0;
        div_start        = 1'b0;
        div_dividend     = dlc_pkg::LUMA_SCALE;
        div_divisor      = deny_reg;
        qctrl.mul_en     = 1'b0;
        qctrl.dither_hi  = qidx_reg[0] ^ qidx_reg[2];
        q_sample         = $signed({2'b00, luma_rd_reg});
        q_mid            = ymid_reg;
        q_scale          = sy_reg;
        case (state_reg)
            dlc_pkg::S_LOAD:    pix_ready = 1'b1;
            dlc_pkg::S_DIVY_GO: div_start = 1'b1;
            dlc_pkg::S_DIVZ_GO:
            begin
                div_start    = 1'b1;
                div_dividend = dlc_pkg::KEY_SCALE;
                div_divisor  = denz_reg;
            end
            dlc_pkg::S_QUANT:
            begin
                qctrl.mul_en = (qphase_reg == 2'd1) || (qphase_reg == 2'd2);
                if (qphase_reg == 2'd2)
                begin
                    q_sample = key_rd_reg;
                    q_mid    = zmid_reg;
                    q_scale  = sz_reg;
                end
            end
            dlc_pkg::S_EMIT:    byte_valid = 1'b1;
            default:            pix_ready = 1'b0;
        endcase
    end

    // ---------------- setup and blend datapath ----------------
    always_comb
    begin
        kmin_c = key_min_reg[9] ? 8'd0 : (key_min_reg > 10'sd255 ? 8'd255 : key_min_reg[7:0]);
        kmax_c = key_max_reg[9] ? 8'd0 : (key_max_reg > 10'sd255 ? 8'd255 : key_max_reg[7:0]);
        ysum   = {1'b0, luma_min_reg} + {1'b0, luma_max_reg};
        zsum   = {1'b0, kmin_c} + {1'b0, kmax_c};
        ymid_c = ysum[8:1];
        zmid_c = zsum[8:1];

        is_high = (step_reg >= 3'd3);
        case (step_reg)
            3'd0, 3'd3: comp = 2'd0;
            3'd1, 3'd4: comp = 2'd1;
            default:    comp = 2'd2;
        endcase
        ep_sel  = is_high ? high_ep_reg[comp] : low_ep_reg[comp];
        sum_sel = sum_reg[comp];
        ep_x    = 17'(ep_sel);
        avg_x   = (17'(sum_sel) + 17'sd8) >>> 4;
        blend   = ((ep_x <<< 3) + (ep_x <<< 2) + ep_x + (avg_x <<< 1) + avg_x) >>> 4;
        // round to the field's step: 4 for v, 8 for u and alpha
        if (comp == 2'd1)
            rounded = (blend + 17'sd2) & ~17'sd3;
        else
            rounded = (blend + 17'sd4) & ~17'sd7;
        if (rounded < 0)
            ep_out = 8'd0;
        else if (rounded > 17'sd255)
            ep_out = 8'd255;
        else
            ep_out = rounded[7:0];

        word_lo = {low_q_reg[0][7:3], low_q_reg[1][7:2], low_q_reg[2][7:3]};
        word_hi = {high_q_reg[0][7:3], high_q_reg[1][7:2], high_q_reg[2][7:3]};

        case (byte_cnt_reg)
            4'd0:    out_byte = luma_max_reg;
            4'd1:    out_byte = luma_min_reg;
            4'd2:    out_byte = lbits_reg[7:0];
            4'd3:    out_byte = lbits_reg[15:8];
            4'd4:    out_byte = lbits_reg[23:16];
            4'd5:    out_byte = lbits_reg[31:24];
            4'd6:    out_byte = lbits_reg[39:32];
            4'd7:    out_byte = lbits_reg[47:40];
            4'd8:    out_byte = word_lo[7:0];
            4'd9:    out_byte = word_lo[15:8];
            4'd10:   out_byte = word_hi[7:0];
            4'd11:   out_byte = word_hi[15:8];
            4'd12:   out_byte = kbits_reg[7:0];
            4'd13:   out_byte = kbits_reg[15:8];
            4'd14:   out_byte = kbits_reg[23:16];
            default: out_byte = kbits_reg[31:24];
        endcase
    end

    assign byte_position = byte_cnt_reg;
    assign last_byte     = (byte_cnt_reg == 4'd15);

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dlc_pkg::S_LOAD;
            count_reg    <= 4'd0;
            luma_min_reg <= 8'd255;
            luma_max_reg <= 8'd0;
            key_min_reg  <= 10'sd255;
            key_max_reg  <= 10'sd0;
            for (int c = 0; c < 3; c++)
            begin
                low_ep_reg[c]  <= 10'sd255;
                high_ep_reg[c] <= 10'sd0;
                sum_reg[c]     <= 14'sd0;
            end
            step_reg     <= 3'd0;
            qidx_reg     <= 4'd0;
            qphase_reg   <= 2'd0;
            byte_cnt_reg <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                dlc_pkg::S_PIXEL:
                begin
                    count_reg <= count_reg + 4'd1;
                    if (pix.z < key_min_reg)
                    begin
                        key_min_reg   <= pix.z;
                        low_ep_reg[0] <= pix.u;
                        low_ep_reg[1] <= pix.v;
                        low_ep_reg[2] <= pix.al;
                    end
                    if (pix.z > key_max_reg)
                    begin
                        key_max_reg    <= pix.z;
                        high_ep_reg[0] <= pix.u;
                        high_ep_reg[1] <= pix.v;
                        high_ep_reg[2] <= pix.al;
                    end
                    if (pix.y < luma_min_reg) luma_min_reg <= pix.y;
                    if (pix.y > luma_max_reg) luma_max_reg <= pix.y;
                    sum_reg[0] <= sum_reg[0] + 14'(pix.u);
                    sum_reg[1] <= sum_reg[1] + 14'(pix.v);
                    sum_reg[2] <= sum_reg[2] + 14'(pix.al);
                end
                dlc_pkg::S_PREP:
                begin
                    step_reg   <= 3'd0;
                    qidx_reg   <= 4'd0;
                    qphase_reg <= 2'd0;
                end
                dlc_pkg::S_BLEND:
                    step_reg <= step_reg + 3'd1;
                dlc_pkg::S_QUANT:
                begin
                    qphase_reg <= qphase_reg + 2'd1;
                    if (qphase_reg == 2'd3)
                        qidx_reg <= qidx_reg + 4'd1;
                end
                dlc_pkg::S_EMIT:
                begin
                    if (byte_ready)
                    begin
                        byte_cnt_reg <= byte_cnt_reg + 4'd1;
                        // block leaves: drop the tile statistics
                        if (byte_cnt_reg == 4'd15)
                        begin
                            luma_min_reg <= 8'd255;
                            luma_max_reg <= 8'd0;
                            key_min_reg  <= 10'sd255;
                            key_max_reg  <= 10'sd0;
                            for (int c = 0; c < 3; c++)
                            begin
                                low_ep_reg[c]  <= 10'sd255;
                                high_ep_reg[c] <= 10'sd0;
                                sum_reg[c]     <= 14'sd0;
                            end
                        end
                    end
                end
                default:
                    count_reg <= count_reg;
            endcase
        end
    end

    // ---------------- payload registers and tile stores ----------------
    always_ff @(posedge clk)
    begin
        if (pix_valid && pix_ready)
        begin
            red_reg   <= red;
            green_reg <= green;
            blue_reg  <= blue;
            alpha_reg <= alpha;
        end
        if (state_reg == dlc_pkg::S_PIXEL)
        begin
            luma_mem[count_reg] <= pix.y;
            key_mem[count_reg]  <= pix.z;
        end
        luma_rd_reg <= luma_mem[qidx_reg];
        key_rd_reg  <= key_mem[qidx_reg];

        if (state_reg == dlc_pkg::S_PREP)
        begin
            ymid_reg <= ymid_c;
            zmid_reg <= zmid_c;
            deny_reg <= luma_max_reg - ymid_c + 8'd1;
            denz_reg <= kmax_c - zmid_c + 8'd1;
        end
        if (state_reg == dlc_pkg::S_BLEND)
        begin
            if (is_high)
                high_q_reg[comp] <= ep_out;
            else
                low_q_reg[comp] <= ep_out;
        end
        if (state_reg == dlc_pkg::S_DIVY_WAIT && div_stat.done)
            sy_reg <= div_stat.quotient;
        if (state_reg == dlc_pkg::S_DIVZ_WAIT && div_stat.done)
            sz_reg <= div_stat.quotient;
        if (state_reg == dlc_pkg::S_QUANT && qphase_reg == 2'd2)
            lbits_reg <= {dlc_pkg::luma_code(q_index), lbits_reg[47:3]};
        if (state_reg == dlc_pkg::S_QUANT && qphase_reg == 2'd3)
            kbits_reg <= {dlc_pkg::key_code(q_index), kbits_reg[31:2]};
    end

    // ---------------- assertions ----------------
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(pix_ready && byte_valid))
        else $error("pixel input open while bytes are pending");

    a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && byte_ready && last_byte) |=> pix_ready)
        else $error("input not reopened after the last byte");

    a_scale_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dlc_pkg::S_QUANT) |-> (sy_reg != 17'd0 && sz_reg != 17'd0))
        else $error("zero index scale during quantization");

    a_pixel_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_ready) |=> !pix_ready)
        else $error("pixel taken on back-to-back cycles");

endmodule

// ===== sv/dlc_pixel_conv.sv =====
// ----------------------------------------------------------------------------
// dlc_pixel_conv
// Converts one RGBA pixel to luma, chroma, alpha and the mixed sort key.
// ----------------------------------------------------------------------------
module dlc_pixel_conv (
    input  logic [7:0]      red,
    input  logic [7:0]      green,
    input  logic [7:0]      blue,
    input  logic [7:0]      alpha,
    output dlc_pkg::pixel_t pix
);

    logic signed [10:0] chroma_diff;
    logic signed [10:0] y_full;
    logic signed [9:0]  du;
    logic signed [9:0]  dv;
    logic [7:0]         abs_u;
    logic [7:0]         abs_v;
    logic [7:0]         chroma_dist;
    logic [4:0]         gain;
    logic signed [15:0] u_gain;
    logic signed [15:0] v_gain;
    logic signed [9:0]  u_val;
    logic signed [9:0]  v_val;
    logic signed [9:0]  a_val;
    logic signed [11:0] key_sum;

    always_comb
    begin
        chroma_diff = $signed({2'b00, green, 1'b0}) - $signed({3'b000, blue})
                    - $signed({3'b000, red});
        y_full = $signed({3'b000, green}) - (chroma_diff >>> 2);
        du     = $signed({2'b00, blue}) - $signed({2'b00, red});
        dv     = chroma_diff[10:1];
        abs_u  = du[9] ? 8'(-du) : du[7:0];
        abs_v  = dv[9] ? 8'(-dv) : dv[7:0];
        chroma_dist = (abs_v > abs_u) ? abs_v : abs_u;
        gain   = dlc_pkg::boost_gain(chroma_dist[5:0]);
        u_gain = du * $signed({1'b0, gain});
        v_gain = dv * $signed({1'b0, gain});

        u_val = du + 10'sd128;
        v_val = dv + 10'sd128;
        a_val = $signed({3'b000, alpha[7:1]});
        if (alpha[7:1] >= dlc_pkg::ALPHA_GATE)
        begin
            if (chroma_dist < 8'd64)
            begin
                u_val = u_gain[9:0] + 10'sd128;
                v_val = v_gain[9:0] + 10'sd128;
                a_val = $signed({1'b0, dlc_pkg::boost_alpha(chroma_dist[5:0])});
            end
            else if (chroma_dist < 8'd128)
            begin
                a_val = 10'sd192;
            end
            else
            begin
                u_val = (du >>> 1) + 10'sd128;
                v_val = (dv >>> 1) + 10'sd128;
                a_val = 10'sd128;
            end
        end

        key_sum = {{2{u_val[9]}}, u_val} + {v_val[9], v_val, 1'b0}
                + {{2{a_val[9]}}, a_val};

        pix.y  = y_full[7:0];
        pix.u  = u_val;
        pix.v  = v_val;
        pix.al = a_val;
        pix.z  = key_sum[11:2];
    end

endmodule

// ===== sv/dlc_divider.sv =====
// ----------------------------------------------------------------------------
// dlc_divider
// Restoring divider, one quotient bit per cycle, for the index scale factors.
// ----------------------------------------------------------------------------
module dlc_divider (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [16:0]          dividend,
    input  logic [7:0]           divisor,
    output dlc_pkg::div_status_t status
);

    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic        done_reg;
    logic        done_next;
    logic [16:0] work_reg;
    logic [16:0] work_next;
    logic [7:0]  rem_reg;
    logic [7:0]  rem_next;
    logic [7:0]  dsr_reg;
    logic [7:0]  dsr_next;
    logic [8:0]  shifted;

    always_comb
    begin
        shifted   = {rem_reg, work_reg[16]};
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        work_next = work_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            cnt_next  = 5'(dlc_pkg::DIV_BITS);
            work_next = dividend;
            rem_next  = 8'd0;
            dsr_next  = (divisor == 8'd0) ? 8'd1 : divisor;
        end
        else if (cnt_reg != 5'd0)
        begin
            cnt_next = cnt_reg - 5'd1;
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next  = 8'(shifted - {1'b0, dsr_reg});
                work_next = {work_reg[15:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[7:0];
                work_next = {work_reg[15:0], 1'b0};
            end
            done_next = (cnt_reg == 5'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 5'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign status.done     = done_reg;
    assign status.quotient = work_reg;

endmodule

// ===== sv/dlc_quant.sv =====
// ----------------------------------------------------------------------------
// dlc_quant
// Shared scaling multiplier: (sample - mid) * scale, dithered, to a 0..15 index.
// ----------------------------------------------------------------------------
module dlc_quant (
    input  logic                 clk,
    input  dlc_pkg::quant_ctrl_t ctrl,
    input  logic signed [9:0]    sample,
    input  logic [7:0]           mid,
    input  logic [16:0]          scale,
    output logic [3:0]           index
);

    logic signed [10:0] diff;
    logic signed [28:0] prod_next;
    logic signed [28:0] prod_reg;
    logic               dither_reg;
    logic signed [31:0] biased;
    logic signed [31:0] scaled;

    always_comb
    begin
        diff      = $signed({sample[9], sample}) - $signed({3'b000, mid});
        prod_next = diff * $signed({1'b0, scale});
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg   <= prod_next;
            dither_reg <= ctrl.dither_hi;
        end
    end

    always_comb
    begin
        biased = {{3{prod_reg[28]}}, prod_reg}
               + (dither_reg ? dlc_pkg::DITHER_HI : dlc_pkg::DITHER_LO);
        scaled = biased >>> 13;
        if (scaled < 0)
            index = 4'd0;
        else if (scaled > 32'sd15)
            index = 4'd15;
        else
            index = scaled[3:0];
    end

endmodule
